### hdl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types, constants and helper functions of the line pixel rasterizer.
// ----------------------------------------------------------------------------
package lpr_pkg;

    // Geometry limits.
    localparam int MAX_SIDE   = 2048;
    localparam int COORD_BITS = 16;

    // Derived widths.
    localparam int CoordW  = COORD_BITS;            // signed endpoint coordinate
    localparam int DeltaW  = COORD_BITS;            // absolute delta / length
    localparam int SideW   = $clog2(MAX_SIDE) + 1;  // effective screen side
    localparam int PixW    = $clog2(MAX_SIDE);      // clamped coordinate
    localparam int ProdW   = PixW + SideW;          // row offset product
    localparam int IndexW  = 22;                    // frame buffer index field
    localparam int ColorW  = 16;                    // pixel color field
    localparam int CfgW    = 12;                    // configuration register width
    localparam int CfgIdxW = 1;                     // configuration register index

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_SCREEN_HEIGHT = 1'b1;

    // Configuration reset values.
    localparam logic [CfgW-1:0] SCREEN_WIDTH_RESET  = CfgW'(640);
    localparam logic [CfgW-1:0] SCREEN_HEIGHT_RESET = CfgW'(480);

    // Input function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    // One pixel between the stepping logic and the index stage.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [PixW-1:0]   x;
        logic [PixW-1:0]   y;
        logic [ColorW-1:0] color;
        logic [SideW-1:0]  stride;
    } pix_t;

    // Limit a screen side register to the range 1 .. MAX_SIDE.
    function automatic logic [SideW-1:0] side_limit(input logic [CfgW-1:0] side_reg);
        logic [SideW-1:0] result;
        if (side_reg == '0)
        begin
            result = SideW'(1);
        end
        else if (32'(side_reg) > MAX_SIDE)
        begin
            result = SideW'(MAX_SIDE);
        end
        else
        begin
            result = SideW'(side_reg);
        end
        return result;
    endfunction

    // Clamp a signed coordinate to 0 .. side-1.
    function automatic logic [PixW-1:0] clamp_coord(input logic signed [CoordW-1:0] value,
                                                    input logic [SideW-1:0] side);
        logic [SideW-1:0] limit;
        logic [PixW-1:0]  result;
        limit = side - SideW'(1);
        if (value[CoordW-1])
        begin
            result = '0;
        end
        else if (32'($unsigned(value)) > 32'(limit))
        begin
            result = limit[PixW-1:0];
        end
        else
        begin
            result = value[PixW-1:0];
        end
        return result;
    endfunction

endpackage

### hdl/line_pixel_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_unit
// Integer DDA line rasterizer that emits one clamped pixel write per item.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid / in_stall): func 0 starts a line from x_start,
//   y_start, x_end, y_end and pen_color; func 1 requests the next pixel.
// - Output channel (out_valid / out_stall): one result per input transaction.
//   pixel_valid is 0 for a step request with no active line. last marks the
//   endpoint, so a line gives major length + 1 pixels.
// - Configuration: cfg_write with cfg_index selects screen_width (0) or
//   screen_height (1); write only while the block is idle.
// - Path: an accepted transaction is registered in the line step stage, then
//   passes the row index multiply into the output register.
// - Throughput: one transaction per cycle while in_stall is low; the DDA step
//   updates the line state on every accepted transaction.
// - A stalled output holds its result; the block keeps accepting until both
//   stages are full, then raises in_stall.
// - Reset clears the line state and both stages and restores the screen size
//   to 640 by 480.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_unit
    import lpr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_write,
    input  logic [CfgIdxW-1:0]       cfg_index,
    input  logic [CfgW-1:0]          cfg_data,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     func,
    input  logic signed [CoordW-1:0] x_start,
    input  logic signed [CoordW-1:0] y_start,
    input  logic signed [CoordW-1:0] x_end,
    input  logic signed [CoordW-1:0] y_end,
    input  logic [ColorW-1:0]        pen_color,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     pixel_valid,
    output logic [IndexW-1:0]        pixel_index,
    output logic [PixW-1:0]          pixel_x,
    output logic [PixW-1:0]          pixel_y,
    output logic [ColorW-1:0]        pixel_color,
    output logic                     last
);

    logic [CfgW-1:0]   width_reg;
    logic [CfgW-1:0]   height_reg;

    logic              in_accept;
    logic              s1_free;
    logic              s2_free;
    pix_t              pix;

    logic              s1_valid_reg;
    pix_t              s1_pix_reg;

    logic [ProdW-1:0]  row_offset;
    logic [IndexW-1:0] index_next;

    logic              out_valid_reg;
    logic              pixel_valid_reg;
    logic [IndexW-1:0] pixel_index_reg;
    logic [PixW-1:0]   pixel_x_reg;
    logic [PixW-1:0]   pixel_y_reg;
    logic [ColorW-1:0] pixel_color_reg;
    logic              last_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    // Pipeline flow control: each stage moves when the next one can take it.
    assign s2_free   = !out_valid_reg || !out_stall;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign in_stall  = !s1_free;
    assign in_accept = in_valid && s1_free;

    // Line stepping and clamping.
    lpr_dda u_dda
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .func       (func),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .pen_color  (pen_color),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .pix        (pix)
    );

    // Stage one register holds the clamped pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_pix_reg <= pix;
        end
    end

    // Linear index: clamped y times the row stride plus clamped x.
    assign row_offset = {{SideW{1'b0}}, s1_pix_reg.y} * {{PixW{1'b0}}, s1_pix_reg.stride};
    assign index_next = IndexW'(row_offset + {{SideW{1'b0}}, s1_pix_reg.x});

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            pixel_valid_reg <= s1_pix_reg.valid;
            pixel_index_reg <= index_next;
            pixel_x_reg     <= s1_pix_reg.x;
            pixel_y_reg     <= s1_pix_reg.y;
            pixel_color_reg <= s1_pix_reg.color;
            last_reg        <= s1_pix_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_valid = pixel_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last        = last_reg;

    // An accepted transaction always lands in stage one.
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted transaction lost before stage one");

    // A blocked stage one keeps its pixel.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |=> (s1_valid_reg && $stable(s1_pix_reg)))
        else $error("stage one changed while blocked");

    // A step without a line delivers an all-zero pixel.
    a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pixel_valid) |-> ((pixel_index == '0) && (pixel_x == '0)
                                          && (pixel_y == '0) && (pixel_color == '0)
                                          && !last))
        else $error("idle step result carries pixel data");

endmodule

### hdl/lpr_dda.sv
// ----------------------------------------------------------------------------
// lpr_dda
// Line state, loaded by a start and advanced one DDA step per accepted step; the
// clamped pixel of each transaction is produced combinationally.
// ----------------------------------------------------------------------------
module lpr_dda
    import lpr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     func,
    input  logic signed [CoordW-1:0] x_start,
    input  logic signed [CoordW-1:0] y_start,
    input  logic signed [CoordW-1:0] x_end,
    input  logic signed [CoordW-1:0] y_end,
    input  logic [ColorW-1:0]        pen_color,
    input  logic [CfgW-1:0]          width_cfg,
    input  logic [CfgW-1:0]          height_cfg,
    output pix_t                     pix
);

    // Line state registers.
    logic signed [CoordW-1:0] cur_x_reg, cur_x_next;
    logic signed [CoordW-1:0] cur_y_reg, cur_y_next;
    logic [DeltaW-1:0]        err_x_reg, err_x_next;
    logic [DeltaW-1:0]        err_y_reg, err_y_next;
    logic [DeltaW-1:0]        abs_dx_reg, abs_dx_next;
    logic [DeltaW-1:0]        abs_dy_reg, abs_dy_next;
    logic [DeltaW-1:0]        major_len_reg, major_len_next;
    logic [DeltaW-1:0]        steps_left_reg, steps_left_next;
    logic signed [1:0]        dir_x_reg, dir_x_next;
    logic signed [1:0]        dir_y_reg, dir_y_next;
    logic [ColorW-1:0]        line_color_reg, line_color_next;
    logic                     line_active_reg, line_active_next;

    // Start-of-line arithmetic.
    logic signed [CoordW:0]   dx;
    logic signed [CoordW:0]   dy;
    logic signed [CoordW:0]   dx_abs;
    logic signed [CoordW:0]   dy_abs;

    // Step arithmetic.
    logic [DeltaW:0]          sum_x;
    logic [DeltaW:0]          sum_y;

    // Emitted pixel.
    logic                     emit_valid;
    logic                     emit_last;
    logic [SideW-1:0]         w_eff;
    logic [SideW-1:0]         h_eff;

    assign dx     = {x_end[CoordW-1], x_end} - {x_start[CoordW-1], x_start};
    assign dy     = {y_end[CoordW-1], y_end} - {y_start[CoordW-1], y_start};
    assign dx_abs = dx[CoordW] ? -dx : dx;
    assign dy_abs = dy[CoordW] ? -dy : dy;

    assign sum_x  = {1'b0, err_x_reg} + {1'b0, abs_dx_reg};
    assign sum_y  = {1'b0, err_y_reg} + {1'b0, abs_dy_reg};

    assign w_eff  = side_limit(width_cfg);
    assign h_eff  = side_limit(height_cfg);

    // Next line state and the pixel that this transaction emits.
    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        err_x_next       = err_x_reg;
        err_y_next       = err_y_reg;
        abs_dx_next      = abs_dx_reg;
        abs_dy_next      = abs_dy_reg;
        major_len_next   = major_len_reg;
        steps_left_next  = steps_left_reg;
        dir_x_next       = dir_x_reg;
        dir_y_next       = dir_y_reg;
        line_color_next  = line_color_reg;
        line_active_next = line_active_reg;
        emit_valid       = 1'b0;
        emit_last        = 1'b0;

        case (func)
            FUNC_START:
            begin
                abs_dx_next      = dx_abs[DeltaW-1:0];
                abs_dy_next      = dy_abs[DeltaW-1:0];
                dir_x_next       = dx[CoordW] ? -2'sd1 : ((dx != '0) ? 2'sd1 : 2'sd0);
                dir_y_next       = dy[CoordW] ? -2'sd1 : ((dy != '0) ? 2'sd1 : 2'sd0);
                major_len_next   = (dx_abs > dy_abs) ? dx_abs[DeltaW-1:0]
                                                     : dy_abs[DeltaW-1:0];
                steps_left_next  = major_len_next;
                err_x_next       = '0;
                err_y_next       = '0;
                cur_x_next       = x_start;
                cur_y_next       = y_start;
                line_color_next  = pen_color;
                line_active_next = (major_len_next != '0);
                emit_valid       = 1'b1;
                emit_last        = (major_len_next == '0);
            end
            FUNC_STEP:
            begin
                if (line_active_reg)
                begin
                    // Each axis advances when its accumulator reaches the length.
                    if (sum_x >= {1'b0, major_len_reg})
                    begin
                        err_x_next = DeltaW'(sum_x - {1'b0, major_len_reg});
                        cur_x_next = cur_x_reg + CoordW'(dir_x_reg);
                    end
                    else
                    begin
                        err_x_next = sum_x[DeltaW-1:0];
                    end
                    if (sum_y >= {1'b0, major_len_reg})
                    begin
                        err_y_next = DeltaW'(sum_y - {1'b0, major_len_reg});
                        cur_y_next = cur_y_reg + CoordW'(dir_y_reg);
                    end
                    else
                    begin
                        err_y_next = sum_y[DeltaW-1:0];
                    end
                    steps_left_next  = steps_left_reg - DeltaW'(1);
                    line_active_next = (steps_left_next != '0);
                    emit_valid       = 1'b1;
                    emit_last        = (steps_left_next == '0);
                end
            end
            default:
            begin
                emit_valid = 1'b0;
            end
        endcase
    end

    // Clamp the new position; a step without a line gives an all-zero pixel.
    always_comb
    begin
        pix = '0;
        if (emit_valid)
        begin
            pix.valid  = 1'b1;
            pix.last   = emit_last;
            pix.x      = clamp_coord(cur_x_next, w_eff);
            pix.y      = clamp_coord(cur_y_next, h_eff);
            pix.color  = line_color_next;
            pix.stride = w_eff;
        end
    end

    // State update on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            err_x_reg       <= '0;
            err_y_reg       <= '0;
            abs_dx_reg      <= '0;
            abs_dy_reg      <= '0;
            major_len_reg   <= '0;
            steps_left_reg  <= '0;
            dir_x_reg       <= '0;
            dir_y_reg       <= '0;
            line_color_reg  <= '0;
            line_active_reg <= 1'b0;
        end
        else if (accept)
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            err_x_reg       <= err_x_next;
            err_y_reg       <= err_y_next;
            abs_dx_reg      <= abs_dx_next;
            abs_dy_reg      <= abs_dy_next;
            major_len_reg   <= major_len_next;
            steps_left_reg  <= steps_left_next;
            dir_x_reg       <= dir_x_next;
            dir_y_reg       <= dir_y_next;
            line_color_reg  <= line_color_next;
            line_active_reg <= line_active_next;
        end
    end

    // An active line always has steps remaining.
    a_active_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (steps_left_reg != '0))
        else $error("active line with no steps left");

    // The accumulators stay below the major length while a line is active.
    a_err_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> ((err_x_reg < major_len_reg) && (err_y_reg < major_len_reg)))
        else $error("error accumulator reached the major length");

endmodule
